### sv/lkc_pkg.sv
// ----------------------------------------------------------------------------
// lkc_pkg: shared types and constants for the keyed LRU cache
// Sizes, request and response payloads, the scan step and result groups, and
// the occupancy saturation helper.
// ----------------------------------------------------------------------------
package lkc_pkg;

   // Cache geometry.
   localparam int CAPACITY        = 128;
   localparam int VALUE_WIDTH     = 32;
   localparam int KEY_WORD_WIDTH  = 64;
   localparam int KEY_WORDS       = 4;
   localparam int KEY_WIDTH       = KEY_WORD_WIDTH * KEY_WORDS;
   localparam int IDX_WIDTH       = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int RANK_WIDTH      = IDX_WIDTH;
   localparam int COUNT_WIDTH     = $clog2(CAPACITY + 1);

   // Fixed field widths of the channels.
   localparam int VALUE_IN_WIDTH  = 32;
   localparam int VALUE_OUT_WIDTH = 32;
   localparam int OCC_WIDTH       = 8;
   localparam int OCC_MAX         = (1 << OCC_WIDTH) - 1;

   // Command codes.
   localparam logic CMD_LOOKUP = 1'b0;
   localparam logic CMD_STORE  = 1'b1;

   typedef struct packed {
      logic                      cmd;
      logic [KEY_WORD_WIDTH-1:0] key_word0;
      logic [KEY_WORD_WIDTH-1:0] key_word1;
      logic [KEY_WORD_WIDTH-1:0] key_word2;
      logic [KEY_WORD_WIDTH-1:0] key_word3;
      logic [VALUE_IN_WIDTH-1:0] value_in;
   } req_type;

   typedef struct packed {
      logic                       hit;
      logic [VALUE_OUT_WIDTH-1:0] value_out;
      logic                       evicted;
      logic [OCC_WIDTH-1:0]       occupancy;
   } rsp_type;

   // One entry presented to the scan unit.
   typedef struct packed {
      logic                   start;
      logic                   step;
      logic [IDX_WIDTH-1:0]   idx;
      logic                   entry_valid;
      logic [KEY_WIDTH-1:0]   row_key;
      logic [KEY_WIDTH-1:0]   req_key;
      logic [RANK_WIDTH-1:0]  rank;
      logic [VALUE_WIDTH-1:0] value;
   } scan_step_type;

   // What the scan unit has found so far.
   typedef struct packed {
      logic                   found;
      logic [IDX_WIDTH-1:0]   match_idx;
      logic [RANK_WIDTH-1:0]  match_rank;
      logic [VALUE_WIDTH-1:0] match_value;
      logic                   free_found;
      logic [IDX_WIDTH-1:0]   free_idx;
      logic [IDX_WIDTH-1:0]   lru_idx;
   } scan_result_type;

   // Occupancy saturates at the top of its field.
   function automatic logic [OCC_WIDTH-1:0] occ_sat(input logic [COUNT_WIDTH-1:0] count);
      logic [OCC_WIDTH-1:0] occ;
      if (32'(count) > OCC_MAX) begin
         occ = OCC_WIDTH'(OCC_MAX);
      end else begin
         occ = OCC_WIDTH'(count);
      end
      return occ;
   endfunction

endpackage

### sv/lkc_ram.sv
// ----------------------------------------------------------------------------
// lkc_ram: generic simple dual-port RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module lkc_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 128
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write and registered read.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### sv/lkc_scan.sv
// ----------------------------------------------------------------------------
// lkc_scan: key compare and victim tracking unit
// Sees one stored entry per cycle and keeps the matching entry, the lowest
// free entry and the valid entry of highest rank.
// ----------------------------------------------------------------------------
module lkc_scan
   import lkc_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  scan_step_type   step_in,
   output scan_result_type result
);

   logic                   found_ff, found_in;
   logic                   free_found_ff, free_found_in;
   logic                   lru_seen_ff, lru_seen_in;
   logic [IDX_WIDTH-1:0]   match_idx_ff, match_idx_in;
   logic [RANK_WIDTH-1:0]  match_rank_ff, match_rank_in;
   logic [VALUE_WIDTH-1:0] match_value_ff, match_value_in;
   logic [IDX_WIDTH-1:0]   free_idx_ff, free_idx_in;
   logic [IDX_WIDTH-1:0]   lru_idx_ff, lru_idx_in;
   logic [RANK_WIDTH-1:0]  lru_rank_ff, lru_rank_in;
   logic                   is_match, is_free, is_older;

   // Compare this entry against the request and the trackers.
   always_comb begin
      is_match = step_in.step && step_in.entry_valid && !found_ff &&
                 (step_in.row_key == step_in.req_key);
      is_free  = step_in.step && !step_in.entry_valid && !free_found_ff;
      is_older = step_in.step && step_in.entry_valid &&
                 (!lru_seen_ff || (step_in.rank > lru_rank_ff));

      found_in       = found_ff || is_match;
      match_idx_in   = is_match ? step_in.idx : match_idx_ff;
      match_rank_in  = is_match ? step_in.rank : match_rank_ff;
      match_value_in = is_match ? step_in.value : match_value_ff;
      free_found_in  = free_found_ff || is_free;
      free_idx_in    = is_free ? step_in.idx : free_idx_ff;
      lru_seen_in    = lru_seen_ff || is_older;
      lru_idx_in     = is_older ? step_in.idx : lru_idx_ff;
      lru_rank_in    = is_older ? step_in.rank : lru_rank_ff;

      if (step_in.start) begin
         found_in      = 1'b0;
         free_found_in = 1'b0;
         lru_seen_in   = 1'b0;
      end
   end

   // Tracker flags clear at reset and at the start of each scan.
   always_ff @(posedge clock) begin
      if (reset) begin
         found_ff      <= 1'b0;
         free_found_ff <= 1'b0;
         lru_seen_ff   <= 1'b0;
      end else begin
         found_ff      <= found_in;
         free_found_ff <= free_found_in;
         lru_seen_ff   <= lru_seen_in;
      end
      match_idx_ff   <= match_idx_in;
      match_rank_ff  <= match_rank_in;
      match_value_ff <= match_value_in;
      free_idx_ff    <= free_idx_in;
      lru_idx_ff     <= lru_idx_in;
      lru_rank_ff    <= lru_rank_in;
   end

   assign result.found       = found_ff;
   assign result.match_idx   = match_idx_ff;
   assign result.match_rank  = match_rank_ff;
   assign result.match_value = match_value_ff;
   assign result.free_found  = free_found_ff;
   assign result.free_idx    = free_idx_ff;
   assign result.lru_idx     = lru_idx_ff;

endmodule

### sv/lru_keyed_cache.sv
// ----------------------------------------------------------------------------
// lru_keyed_cache: fully associative least-recently-used cache
// Pairs 256-bit keys with value handles, keeps a recency rank per entry and
// evicts the least recent entry when a store misses in a full cache.
// ----------------------------------------------------------------------------
//
//   Channel  Direction  Handshake             Payload
//   req_     in         req_valid/req_ready   req_type: cmd, key words, value
//   rsp_     out        rsp_valid/rsp_ready   rsp_type: hit, value, evicted, occ
//
// A lookup miss has its response loaded after the key compare walk alone,
// every other request also after the rank update walk: one shared read
// address walks every entry once for the key compare and once more for the
// rank update. The next request is accepted once the response is loaded.
// Reset clears the valid bits and the entry count directly; no sweep.
// A response waits in its output register; while it is not taken the next
// request still runs and only its own response waits.
//
module lru_keyed_cache
   import lkc_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DRAIN,
      ST_PLAN,
      ST_PROMOTE,
      ST_FLUSH,
      ST_RESP
   } state_type;

   localparam logic [IDX_WIDTH-1:0] LAST_IDX = IDX_WIDTH'(CAPACITY - 1);

   state_type              state_ff, state_in;
   logic [IDX_WIDTH-1:0]   addr_ff, addr_in;
   logic                   step_ff, step_in;
   logic [IDX_WIDTH-1:0]   step_idx_ff, step_idx_in;
   req_type                req_ff, req_in;
   logic [CAPACITY-1:0]    valid_ff, valid_in;
   logic [COUNT_WIDTH-1:0] count_ff, count_in;
   logic                   insert_ff, insert_in;
   logic [IDX_WIDTH-1:0]   target_ff, target_in;
   logic [RANK_WIDTH-1:0]  limit_ff, limit_in;
   rsp_type                res_ff, res_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   rsp_type                rsp_data_ff, rsp_data_in;

   logic                   key_wr_en;
   logic [IDX_WIDTH-1:0]   key_wr_addr;
   logic [KEY_WIDTH-1:0]   key_rd;
   logic                   value_wr_en;
   logic [IDX_WIDTH-1:0]   value_wr_addr;
   logic [VALUE_WIDTH-1:0] value_rd;
   logic                   rank_wr_en;
   logic [RANK_WIDTH-1:0]  rank_wr_data;
   logic [RANK_WIDTH-1:0]  rank_rd;
   logic [KEY_WIDTH-1:0]   req_key;
   logic                   full;
   logic                   is_store;
   logic                   rank_active;
   logic [IDX_WIDTH-1:0]   slot;
   scan_step_type          scan_step;
   scan_result_type        scan_res;

   assign req_key  = {req_ff.key_word3, req_ff.key_word2, req_ff.key_word1,
                      req_ff.key_word0};
   assign full     = (count_ff == COUNT_WIDTH'(CAPACITY));
   assign is_store = (req_ff.cmd == CMD_STORE);
   assign slot     = full ? scan_res.lru_idx : scan_res.free_idx;

   // Entry stores, all walked through one shared read address.
   lkc_ram #(.WIDTH(KEY_WIDTH), .DEPTH(CAPACITY)) u_key_ram (
      .clock   (clock),
      .wr_en   (key_wr_en),
      .wr_addr (key_wr_addr),
      .wr_data (req_key),
      .rd_addr (addr_ff),
      .rd_data (key_rd)
   );

   lkc_ram #(.WIDTH(VALUE_WIDTH), .DEPTH(CAPACITY)) u_value_ram (
      .clock   (clock),
      .wr_en   (value_wr_en),
      .wr_addr (value_wr_addr),
      .wr_data (VALUE_WIDTH'(req_ff.value_in)),
      .rd_addr (addr_ff),
      .rd_data (value_rd)
   );

   lkc_ram #(.WIDTH(RANK_WIDTH), .DEPTH(CAPACITY)) u_rank_ram (
      .clock   (clock),
      .wr_en   (rank_wr_en),
      .wr_addr (step_idx_ff),
      .wr_data (rank_wr_data),
      .rd_addr (addr_ff),
      .rd_data (rank_rd)
   );

   // Key compare and victim search over the read data of the walk.
   always_comb begin
      scan_step.start       = (state_ff == ST_IDLE) && req_valid;
      scan_step.step        = step_ff && ((state_ff == ST_SCAN) || (state_ff == ST_DRAIN));
      scan_step.idx         = step_idx_ff;
      scan_step.entry_valid = valid_ff[step_idx_ff];
      scan_step.row_key     = key_rd;
      scan_step.req_key     = req_key;
      scan_step.rank        = rank_rd;
      scan_step.value       = value_rd;
   end

   lkc_scan u_scan (
      .clock   (clock),
      .reset   (reset),
      .step_in (scan_step),
      .result  (scan_res)
   );

   // Ranks: promoted entry gets zero, younger valid ones age (all on insert).
   always_comb begin
      rank_active  = step_ff && ((state_ff == ST_PROMOTE) || (state_ff == ST_FLUSH));
      rank_wr_en   = 1'b0;
      rank_wr_data = rank_rd + RANK_WIDTH'(1);
      if (rank_active) begin
         if (step_idx_ff == target_ff) begin
            rank_wr_en   = 1'b1;
            rank_wr_data = '0;
         end else if (valid_ff[step_idx_ff] && (insert_ff || (rank_rd < limit_ff))) begin
            rank_wr_en = 1'b1;
         end
      end
   end

   // Sequencer.
   always_comb begin
      state_in      = state_ff;
      addr_in       = addr_ff;
      step_in       = 1'b0;
      step_idx_in   = addr_ff;
      req_in        = req_ff;
      valid_in      = valid_ff;
      count_in      = count_ff;
      insert_in     = insert_ff;
      target_in     = target_ff;
      limit_in      = limit_ff;
      res_in        = res_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_data_in   = rsp_data_ff;
      key_wr_en     = 1'b0;
      key_wr_addr   = slot;
      value_wr_en   = 1'b0;
      value_wr_addr = slot;

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               req_in   = req_data;
               addr_in  = '0;
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            step_in = 1'b1;
            if (addr_ff == LAST_IDX) begin
               addr_in  = '0;
               state_in = ST_DRAIN;
            end else begin
               addr_in = addr_ff + IDX_WIDTH'(1);
            end
         end
         ST_DRAIN: begin
            state_in = ST_PLAN;
         end
         ST_PLAN: begin
            res_in.hit       = scan_res.found;
            res_in.value_out = '0;
            res_in.evicted   = 1'b0;
            res_in.occupancy = '0;
            addr_in          = '0;
            if (scan_res.found) begin
               // Hit: update or read the value, then promote the entry.
               if (is_store) begin
                  value_wr_en   = 1'b1;
                  value_wr_addr = scan_res.match_idx;
               end else begin
                  res_in.value_out = VALUE_OUT_WIDTH'(scan_res.match_value);
               end
               insert_in = 1'b0;
               target_in = scan_res.match_idx;
               limit_in  = scan_res.match_rank;
               state_in  = ST_PROMOTE;
            end else if (is_store) begin
               // Miss on a store: fill a free entry or replace the oldest one.
               key_wr_en      = 1'b1;
               value_wr_en    = 1'b1;
               valid_in[slot] = 1'b1;
               res_in.evicted = full;
               if (!full) begin
                  count_in = count_ff + COUNT_WIDTH'(1);
               end
               insert_in = 1'b1;
               target_in = slot;
               state_in  = ST_PROMOTE;
            end else begin
               state_in = ST_RESP;
            end
         end
         ST_PROMOTE: begin
            step_in = 1'b1;
            if (addr_ff == LAST_IDX) begin
               addr_in  = '0;
               state_in = ST_FLUSH;
            end else begin
               addr_in = addr_ff + IDX_WIDTH'(1);
            end
         end
         ST_FLUSH: begin
            state_in = ST_RESP;
         end
         ST_RESP: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in          = 1'b1;
               rsp_data_in           = res_ff;
               rsp_data_in.occupancy = occ_sat(count_ff);
               state_in              = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // State and registered outputs.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         step_ff      <= 1'b0;
         valid_ff     <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         valid_ff     <= valid_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      addr_ff     <= addr_in;
      step_idx_ff <= step_idx_in;
      req_ff      <= req_in;
      insert_ff   <= insert_in;
      target_ff   <= target_in;
      limit_ff    <= limit_in;
      res_ff      <= res_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // The entry count always matches the valid bits between requests.
   a_count_matches_valid: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> ($countones(valid_ff) == 32'(count_ff)))
      else $error("entry count differs from the number of valid entries");

   // A store miss with room must have found a free entry.
   a_free_slot_found: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == ST_PLAN) && is_store && !scan_res.found && !full)
      |-> scan_res.free_found)
      else $error("store miss with room found no free entry");

   // Aging never pushes a rank past the last position.
   a_rank_no_overflow: assert property (@(posedge clock) disable iff (reset)
      (rank_wr_en && (step_idx_ff != target_ff)) |-> (rank_rd != RANK_WIDTH'(CAPACITY - 1)))
      else $error("recency rank overflow during promotion");

   // A response is loaded only from the response state.
   a_rsp_from_resp: assert property (@(posedge clock) disable iff (reset)
      ($rose(rsp_valid_ff) || (rsp_valid_ff && $past(rsp_ready) && $past(rsp_valid_ff)))
      |-> ($past(state_ff) == ST_RESP))
      else $error("response raised outside the response state");

endmodule

### verif/tb_lru_keyed_cache.sv
// ----------------------------------------------------------------------------
// tb_lru_keyed_cache: self-checking testbench for the keyed LRU cache
// Drives lookup and store requests through the valid/ready request channel,
// predicts every response with a behavioral copy of the cache, and compares
// the responses field by field. The traffic fills the cache past capacity so
// that least-recent eviction is exercised. Both channels idle at random.
// ----------------------------------------------------------------------------
module tb_lru_keyed_cache;
   timeunit 1ns;
   timeprecision 1ps;

   import lkc_pkg::*;

   localparam int RANDOM_REQUESTS = 530;
   localparam int KEY_HISTORY_MAX = 200;
   localparam int QUIET_LIMIT     = 6000;
   localparam int TAIL_CYCLES     = 300;

   // Behavioral cache: predicts one response per accepted request.
   class cache_scoreboard;
      logic [KEY_WIDTH-1:0]   keys [CAPACITY];
      logic [VALUE_WIDTH-1:0] vals [CAPACITY];
      bit                     used [CAPACITY];
      int unsigned            age  [CAPACITY];
      int unsigned            filled;
      rsp_type                expected_q [$];
      int                     errors;
      int                     n_lookups;
      int                     n_stores;
      int                     n_hits;
      int                     n_evictions;
      int                     n_checked;
      int unsigned            peak_fill;

      function new();
         for (int i = 0; i < CAPACITY; i++) begin
            used[i] = 1'b0;
         end
         filled = 0;
      endfunction

      // Entry e becomes most recent; valid entries younger than limit age by one.
      function void make_recent(int e, int unsigned limit);
         for (int i = 0; i < CAPACITY; i++) begin
            if (i != e && used[i] && age[i] < limit) begin
               age[i]++;
            end
         end
         age[e] = 0;
      endfunction

      // Update the cache copy for an accepted request and queue its response.
      function void note_request(req_type r);
         logic [KEY_WIDTH-1:0] k;
         rsp_type              e;
         int                   slot;
         int unsigned          oldest;
         k = {r.key_word3, r.key_word2, r.key_word1, r.key_word0};
         e = '0;
         slot = -1;
         for (int i = 0; i < CAPACITY; i++) begin
            if (slot < 0 && used[i] && keys[i] == k) begin
               slot = i;
            end
         end
         if (r.cmd == CMD_STORE) begin
            n_stores++;
         end else begin
            n_lookups++;
         end
         if (slot >= 0) begin
            e.hit = 1'b1;
            n_hits++;
            if (r.cmd == CMD_STORE) begin
               vals[slot] = VALUE_WIDTH'(r.value_in);
            end else begin
               e.value_out = VALUE_OUT_WIDTH'(vals[slot]);
            end
            make_recent(slot, age[slot]);
         end else if (r.cmd == CMD_STORE) begin
            if (filled >= CAPACITY) begin
               // Full: the valid entry with the highest rank goes.
               oldest = 0;
               for (int i = 0; i < CAPACITY; i++) begin
                  if (used[i] && (slot < 0 || age[i] > oldest)) begin
                     slot = i;
                     oldest = age[i];
                  end
               end
               used[slot] = 1'b0;
               filled--;
               e.evicted = 1'b1;
               n_evictions++;
            end else begin
               // Room left: the lowest-numbered free entry is filled.
               for (int i = CAPACITY - 1; i >= 0; i--) begin
                  if (!used[i]) begin
                     slot = i;
                  end
               end
            end
            keys[slot] = k;
            vals[slot] = VALUE_WIDTH'(r.value_in);
            make_recent(slot, 32'hFFFF_FFFF);
            used[slot] = 1'b1;
            filled++;
         end
         if (filled > peak_fill) begin
            peak_fill = filled;
         end
         e.occupancy = (filled > OCC_MAX) ? OCC_WIDTH'(OCC_MAX) : OCC_WIDTH'(filled);
         expected_q = {expected_q, e};
      endfunction

      function void compare_field(string name, logic [31:0] want, logic [31:0] got);
         if (got !== want) begin
            errors++;
            $display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
         end
      endfunction

      // Compare an accepted response with the oldest prediction.
      function void check_response(rsp_type a);
         rsp_type e;
         if (expected_q.size() == 0) begin
            errors++;
            $display("%0t ns: unexpected response, expected none, actual %0h", $time, a);
         end else begin
            e = expected_q.pop_front();
            n_checked++;
            compare_field("hit", 32'(e.hit), 32'(a.hit));
            compare_field("value_out", 32'(e.value_out), 32'(a.value_out));
            compare_field("evicted", 32'(e.evicted), 32'(a.evicted));
            compare_field("occupancy", 32'(e.occupancy), 32'(a.occupancy));
         end
      endfunction

      function int pending();
         return expected_q.size();
      endfunction
   endclass

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_ready;
   req_type req_data;
   logic    rsp_valid;
   logic    rsp_ready;
   rsp_type rsp_data;

   cache_scoreboard sb;
   int              burst_left;
   int              n_sent;

   lru_keyed_cache uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   // 20 ns clock.
   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   function automatic logic [KEY_WORD_WIDTH-1:0] random_word();
      logic [KEY_WORD_WIDTH-1:0] w;
      case ($urandom_range(0, 15))
         0: begin
            w = '0;
         end
         1: begin
            w = '1;
         end
         default: begin
            w = {$urandom, $urandom};
         end
      endcase
      return w;
   endfunction

   function automatic logic [KEY_WIDTH-1:0] random_key();
      return {random_word(), random_word(), random_word(), random_word()};
   endfunction

   function automatic req_type make_request(logic op, logic [KEY_WIDTH-1:0] k,
                                            logic [VALUE_IN_WIDTH-1:0] v);
      req_type r;
      r.cmd       = op;
      r.key_word0 = k[0*KEY_WORD_WIDTH +: KEY_WORD_WIDTH];
      r.key_word1 = k[1*KEY_WORD_WIDTH +: KEY_WORD_WIDTH];
      r.key_word2 = k[2*KEY_WORD_WIDTH +: KEY_WORD_WIDTH];
      r.key_word3 = k[3*KEY_WORD_WIDTH +: KEY_WORD_WIDTH];
      r.value_in  = v;
      return r;
   endfunction

   // Present one request, wait for acceptance, then maybe idle between bursts.
   task automatic send_request(input req_type r);
      int gap;
      req_valid <= 1'b1;
      req_data  <= r;
      @(posedge clock);
      while (!req_ready) begin
         @(posedge clock);
      end
      sb.note_request(r);
      n_sent++;
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         burst_left = $urandom_range(0, 11);
         case ($urandom_range(0, 7))
            4, 5: begin
               gap = $urandom_range(1, 5);
            end
            6: begin
               gap = $urandom_range(10, 100);
            end
            7: begin
               gap = $urandom_range(100, 300);
            end
            default: begin
               gap = 0;
            end
         endcase
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
   endtask

   // Hold off new requests until every predicted response has come back.
   task automatic drain_responses();
      req_valid <= 1'b0;
      while (sb.pending() != 0) begin
         @(posedge clock);
      end
   endtask

   // Response checker.
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         sb.check_response(rsp_data);
      end
   end

   // Receiver: mixes always ready, random stalls, long stalls and toggling.
   initial begin : receiver
      int span;
      int mode;
      rsp_ready <= 1'b0;
      @(posedge clock);
      while (reset) begin
         @(posedge clock);
      end
      forever begin
         mode = $urandom_range(0, 9);
         span = $urandom_range(50, 800);
         if (mode >= 7) begin
            span = $urandom_range(1, 400);
         end
         repeat (span) begin
            case (mode)
               0, 1, 2, 3: begin
                  rsp_ready <= 1'b1;
               end
               4, 5, 6: begin
                  rsp_ready <= 1'($urandom_range(0, 1));
               end
               7, 8: begin
                  rsp_ready <= 1'b0;
               end
               default: begin
                  rsp_ready <= ~rsp_ready;
               end
            endcase
            @(posedge clock);
         end
      end
   end

   // Watchdog: ends the run if neither channel moves for too long.
   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < QUIET_LIMIT) begin
         @(posedge clock);
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
            quiet = 0;
         end else begin
            quiet++;
         end
      end
      $display("%0t ns: no handshake for %0d cycles", $time, QUIET_LIMIT);
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   // Stimulus: directed requests, then random traffic over a pool of keys.
   initial begin : stimulus
      logic [KEY_WIDTH-1:0] k;
      logic [KEY_WIDTH-1:0] key_history [$];
      logic                 op;
      int                   sel;
      int                   word;
      sb = new();
      burst_left = 0;
      n_sent = 0;
      reset     <= 1'b1;
      req_valid <= 1'b0;
      req_data  <= '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Empty cache, extreme keys and values, update in place.
      send_request(make_request(CMD_LOOKUP, '0, '1));
      send_request(make_request(CMD_STORE, '0, '0));
      send_request(make_request(CMD_STORE, '1, '1));
      send_request(make_request(CMD_LOOKUP, '1, '0));
      send_request(make_request(CMD_LOOKUP, '0, '1));
      send_request(make_request(CMD_STORE, '0, 32'hA5A5_5A5A));
      send_request(make_request(CMD_LOOKUP, '0, '0));

      // Keys that match a stored key in all but one word must miss.
      for (int w = 0; w < KEY_WORDS; w++) begin
         k = '1;
         k[w*KEY_WORD_WIDTH +: KEY_WORD_WIDTH] = '0;
         send_request(make_request(CMD_LOOKUP, k, '1));
      end
      for (int w = 0; w < KEY_WORDS; w++) begin
         k = '0;
         k[w*KEY_WORD_WIDTH +: KEY_WORD_WIDTH] = '1;
         send_request(make_request(CMD_STORE, k, VALUE_IN_WIDTH'(w + 1)));
      end
      k = '0;
      k[2*KEY_WORD_WIDTH +: KEY_WORD_WIDTH] = '1;
      send_request(make_request(CMD_LOOKUP, k, '0));

      // Alternating bit patterns, and an update of the all-ones key.
      k = {KEY_WORDS{64'h5555_5555_5555_5555}};
      send_request(make_request(CMD_STORE, k, 32'h8000_0000));
      send_request(make_request(CMD_LOOKUP, k, 32'hAAAA_AAAA));
      send_request(make_request(CMD_STORE, '1, 32'h0000_0001));
      send_request(make_request(CMD_LOOKUP, '1, 32'h5555_5555));
      drain_responses();

      // Random traffic: fresh stores fill the cache and force evictions,
      // reuse of recent keys hits or finds evicted entries, and fresh
      // lookups miss.
      for (int n = 0; n < RANDOM_REQUESTS; n++) begin
         sel = $urandom_range(0, 99);
         if (sel < 45 || key_history.size() == 0) begin
            k = random_key();
            if (key_history.size() != 0 && $urandom_range(0, 3) == 0) begin
               k = key_history[$urandom_range(0, key_history.size() - 1)];
               word = $urandom_range(0, KEY_WORDS - 1);
               k[word*KEY_WORD_WIDTH +: KEY_WORD_WIDTH] = random_word();
            end
            op = CMD_STORE;
            key_history = {key_history, k};
            if (key_history.size() > KEY_HISTORY_MAX) begin
               void'(key_history.pop_front());
            end
         end else if (sel < 88) begin
            k = key_history[$urandom_range(0, key_history.size() - 1)];
            op = ($urandom_range(0, 1) == 1) ? CMD_STORE : CMD_LOOKUP;
         end else begin
            k = random_key();
            op = CMD_LOOKUP;
         end
         send_request(make_request(op, k, $urandom));
         if (n == RANDOM_REQUESTS / 2) begin
            drain_responses();
         end
      end

      // Let the last responses arrive, then allow a full request time more.
      drain_responses();
      repeat (TAIL_CYCLES) @(posedge clock);

      $display("Sent %0d requests: %0d lookups and %0d stores; %0d responses checked.",
               n_sent, sb.n_lookups, sb.n_stores, sb.n_checked);
      $display("Saw %0d hits and %0d evictions; occupancy peaked at %0d of %0d entries.",
               sb.n_hits, sb.n_evictions, sb.peak_fill, CAPACITY);
      if (sb.errors == 0 && sb.pending() == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
